>>> sv/lqi_pkg.sv
package lqi_pkg;

   localparam int STATES_DEF   = 8;
   localparam int CHANNELS_DEF = 4;
   localparam int CHAN_IDX_W   = 3;
   localparam int ELEM_IDX_W   = 4;
   localparam int DIV_STEPS    = 48;
   localparam int STEP_W       = 6;

   typedef enum logic [2:0] {
      OP_LOAD_L   = 3'd0,
      OP_LOAD_LI  = 3'd1,
      OP_LOAD_X   = 3'd2,
      OP_LOAD_Y   = 3'd3,
      OP_LOAD_R   = 3'd4,
      OP_COMPUTE  = 3'd5
   } opcode_type;

   typedef enum logic [1:0] {
      WINDUP_ALWAYS   = 2'd0,
      WINDUP_CLEAR    = 2'd1,
      WINDUP_HOLD     = 2'd2,
      WINDUP_FALLBACK = 2'd3
   } windup_type;

   typedef enum logic [0:0] {
      CSR_REF_GAIN = 1'b0,
      CSR_WINDUP   = 1'b1
   } csr_index_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_INT,
      S_LX_RD,
      S_LX_MUL,
      S_LX_ACC,
      S_LI_RD,
      S_LI_MUL,
      S_LI_ACC,
      S_DIV_RD,
      S_DIV_INIT,
      S_DIV_STEP,
      S_FF_MUL,
      S_DRIVE,
      S_OUT
   } state_type;

   typedef enum logic [3:0] {
      DP_NOP,
      DP_LOAD,
      DP_INTEG,
      DP_CLR_ACC,
      DP_MUL_LX,
      DP_MUL_LIXI,
      DP_ACC_ADD,
      DP_ACC_SUB,
      DP_DIV_INIT,
      DP_DIV_STEP,
      DP_MUL_FF,
      DP_DRIVE
   } dp_op_type;

   typedef struct packed {
      dp_op_type               op;
      logic [CHAN_IDX_W-1:0]   chan;
      logic [ELEM_IDX_W-1:0]   elem;
      logic                    last;
   } dp_cmd_type;

   typedef struct packed {
      logic out_fire;
   } dp_status_type;

   function automatic logic signed [47:0] rnd_q16(input logic signed [63:0] p);
      logic signed [63:0] t;
      t = p + 64'sd32768;
      return t[63:16];
   endfunction

endpackage

>>> sv/lqi_ram.sv
module lqi_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

>>> sv/lqi_ctrl.sv
module lqi_ctrl import lqi_pkg::*; #(
   parameter int STATES   = STATES_DEF,
   parameter int CHANNELS = CHANNELS_DEF
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [2:0]    opcode,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   state_type             state_ff, state_in;
   logic [CHAN_IDX_W-1:0] chan_ff, chan_in;
   logic [ELEM_IDX_W-1:0] elem_ff, elem_in;
   logic [STEP_W-1:0]     step_ff, step_in;
   logic                  chan_end, st_end, ch_end;

   assign chan_end = (chan_ff == CHAN_IDX_W'(CHANNELS - 1));
   assign st_end   = (elem_ff == ELEM_IDX_W'(STATES - 1));
   assign ch_end   = (elem_ff == ELEM_IDX_W'(CHANNELS - 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         chan_ff  <= '0;
         elem_ff  <= '0;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         chan_ff  <= chan_in;
         elem_ff  <= elem_in;
         step_ff  <= step_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      chan_in    = chan_ff;
      elem_in    = elem_ff;
      step_in    = step_ff;
      req_tready = 1'b0;
      cmd.op     = DP_NOP;
      cmd.chan   = chan_ff;
      cmd.elem   = elem_ff;
      cmd.last   = chan_end;
      unique case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            chan_in    = '0;
            elem_in    = '0;
            if (req_tvalid) begin
               unique case (opcode)
                  OP_LOAD_L, OP_LOAD_LI, OP_LOAD_X, OP_LOAD_Y, OP_LOAD_R: begin
                     cmd.op = DP_LOAD;
                  end
                  OP_COMPUTE: begin
                     state_in = S_INT;
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_INT: begin
            cmd.op = DP_INTEG;
            if (chan_end) begin
               chan_in  = '0;
               elem_in  = '0;
               state_in = S_LX_RD;
            end else begin
               chan_in = chan_ff + 1'b1;
            end
         end
         S_LX_RD: begin
            if (elem_ff == '0) begin
               cmd.op = DP_CLR_ACC;
            end
            state_in = S_LX_MUL;
         end
         S_LX_MUL: begin
            cmd.op   = DP_MUL_LX;
            state_in = S_LX_ACC;
         end
         S_LX_ACC: begin
            cmd.op = DP_ACC_ADD;
            if (st_end) begin
               elem_in  = '0;
               state_in = S_LI_RD;
            end else begin
               elem_in  = elem_ff + 1'b1;
               state_in = S_LX_RD;
            end
         end
         S_LI_RD: begin
            state_in = S_LI_MUL;
         end
         S_LI_MUL: begin
            cmd.op   = DP_MUL_LIXI;
            state_in = S_LI_ACC;
         end
         S_LI_ACC: begin
            cmd.op = DP_ACC_SUB;
            if (ch_end) begin
               elem_in  = '0;
               state_in = S_DIV_RD;
            end else begin
               elem_in  = elem_ff + 1'b1;
               state_in = S_LI_RD;
            end
         end
         S_DIV_RD: begin
            state_in = S_DIV_INIT;
         end
         S_DIV_INIT: begin
            cmd.op   = DP_DIV_INIT;
            step_in  = '0;
            state_in = S_DIV_STEP;
         end
         S_DIV_STEP: begin
            cmd.op = DP_DIV_STEP;
            if (step_ff == STEP_W'(DIV_STEPS - 1)) begin
               state_in = S_FF_MUL;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         S_FF_MUL: begin
            cmd.op   = DP_MUL_FF;
            state_in = S_DRIVE;
         end
         S_DRIVE: begin
            cmd.op   = DP_DRIVE;
            state_in = S_OUT;
         end
         S_OUT: begin
            if (status.out_fire) begin
               if (chan_end) begin
                  state_in = S_IDLE;
               end else begin
                  chan_in  = chan_ff + 1'b1;
                  elem_in  = '0;
                  state_in = S_LX_RD;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

>>> sv/lqi_dp.sv
module lqi_dp import lqi_pkg::*; #(
   parameter int STATES   = STATES_DEF,
   parameter int CHANNELS = CHANNELS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_we,
   input  logic [0:0]         csr_addr,
   input  logic [31:0]        csr_wdata,
   input  logic [2:0]         opcode,
   input  logic [1:0]         row_index,
   input  logic [2:0]         column_index,
   input  logic signed [31:0] value,
   input  dp_cmd_type         cmd,
   output dp_status_type      status,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [1:0]         rsp_channel,
   output logic signed [31:0] rsp_drive,
   output logic               rsp_last,
   output logic               rsp_overflow
);

   localparam int SW    = (STATES > 1) ? $clog2(STATES) : 1;
   localparam int CHW   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int LDEP  = CHANNELS * STATES;
   localparam int IDEP  = CHANNELS * CHANNELS;
   localparam int LAW   = (LDEP > 1) ? $clog2(LDEP) : 1;
   localparam int IAW   = (IDEP > 1) ? $clog2(IDEP) : 1;
   localparam int ACCW  = 49 + $clog2(STATES + CHANNELS);
   localparam int DW    = ACCW + 1;

   logic signed [31:0] xvec_ff [STATES];
   logic signed [31:0] meas_ff [CHANNELS];
   logic signed [31:0] refv_ff [CHANNELS];
   logic signed [31:0] xi_ff   [CHANNELS];
   logic               ovi_ff  [CHANNELS];
   logic signed [31:0] qi_ff;
   logic [1:0]         mode_ff;
   logic signed [63:0] prod_ff;
   logic signed [ACCW-1:0] acc_ff;
   logic [33:0]        rem_ff;
   logic [47:0]        quot_ff;
   logic [33:0]        dmag_ff;
   logic               neg_ff;
   logic               qsat_ff;
   logic               out_valid_ff;
   logic [1:0]         out_chan_ff;
   logic signed [31:0] out_drive_ff;
   logic               out_last_ff;
   logic               out_ovf_ff;

   logic [CHW-1:0]     ci;
   logic [SW-1:0]      xe;
   logic [CHW-1:0]     ie;
   logic               row_ok, col_s_ok, col_c_ok;
   logic               we_l, we_i;
   logic [LAW-1:0]     waddr_l, raddr_l;
   logic [IAW-1:0]     waddr_i, raddr_i;
   logic [31:0]        rdata_l, rdata_i;
   logic signed [33:0] isum;
   logic               isat, integ_on;
   logic signed [31:0] isat_val;
   logic signed [33:0] dval;
   logic               dzero;
   logic signed [47:0] nval;
   logic [47:0]        nmag;
   logic [34:0]        rem_sh;
   logic               rem_ge;
   logic signed [48:0] qfull;
   logic               qpos_ov, qneg_ov;
   logic signed [31:0] qsat_val;
   logic signed [47:0] prnd;
   logic signed [DW-1:0] dv;
   logic               dpos_ov, dneg_ov;
   logic signed [31:0] dsat_val;

   assign ci = cmd.chan[CHW-1:0];
   assign xe = cmd.elem[SW-1:0];
   assign ie = cmd.elem[CHW-1:0];

   assign row_ok   = (int'(row_index) < CHANNELS);
   assign col_s_ok = (int'(column_index) < STATES);
   assign col_c_ok = (int'(column_index) < CHANNELS);
   assign we_l = (cmd.op == DP_LOAD) && (opcode == OP_LOAD_L) && row_ok && col_s_ok;
   assign we_i = (cmd.op == DP_LOAD) && (opcode == OP_LOAD_LI) && row_ok && col_c_ok;
   assign waddr_l = LAW'(int'(row_index) * STATES + int'(column_index));
   assign waddr_i = IAW'(int'(row_index) * CHANNELS + int'(column_index));
   assign raddr_l = LAW'(int'(cmd.chan) * STATES + int'(cmd.elem));
   assign raddr_i = IAW'(int'(cmd.chan) * CHANNELS + int'(cmd.elem));

   lqi_ram #(.WIDTH(32), .DEPTH(LDEP)) u_state_gain (
      .clock (clock),
      .we    (we_l),
      .waddr (waddr_l),
      .wdata (value),
      .raddr (raddr_l),
      .rdata (rdata_l)
   );

   lqi_ram #(.WIDTH(32), .DEPTH(IDEP)) u_integral_gain (
      .clock (clock),
      .we    (we_i),
      .waddr (waddr_i),
      .wdata (value),
      .raddr (raddr_i),
      .rdata (rdata_i)
   );

   always_comb begin
      isum = 34'(xi_ff[ci]) + 34'(refv_ff[ci]) - 34'(meas_ff[ci]);
      isat = (isum[33:31] != 3'b000) && (isum[33:31] != 3'b111);
      if (!isat) begin
         isat_val = isum[31:0];
      end else if (isum[33]) begin
         isat_val = 32'sh80000000;
      end else begin
         isat_val = 32'sh7FFFFFFF;
      end
      integ_on = (mode_ff == WINDUP_ALWAYS) || (mode_ff == WINDUP_FALLBACK)
                 || (refv_ff[ci] > meas_ff[ci]);
   end

   always_comb begin
      dval  = 34'sd65536 - 34'(qi_ff);
      dzero = (dval == '0);
      nval  = {rdata_i, 16'h0000};
      nmag  = nval[47] ? 48'(-nval) : 48'(nval);
      rem_sh = {rem_ff, quot_ff[47]};
      rem_ge = (rem_sh >= {1'b0, dmag_ff});
      qfull  = neg_ff ? -$signed({1'b0, quot_ff}) : $signed({1'b0, quot_ff});
      qpos_ov = !qfull[48] && (qfull[48:31] != '0);
      qneg_ov = qfull[48] && (qfull[48:31] != '1);
      if (qpos_ov) begin
         qsat_val = 32'sh7FFFFFFF;
      end else if (qneg_ov) begin
         qsat_val = 32'sh80000000;
      end else begin
         qsat_val = qfull[31:0];
      end
      prnd = rnd_q16(prod_ff);
      dv   = DW'(prnd) - DW'(acc_ff);
      dpos_ov = !dv[DW-1] && (dv[DW-1:31] != '0);
      dneg_ov = dv[DW-1] && (dv[DW-1:31] != '1);
      if (dpos_ov) begin
         dsat_val = 32'sh7FFFFFFF;
      end else if (dneg_ov) begin
         dsat_val = 32'sh80000000;
      end else begin
         dsat_val = dv[31:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         qi_ff   <= '0;
         mode_ff <= WINDUP_ALWAYS;
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_REF_GAIN: qi_ff   <= csr_wdata;
            CSR_WINDUP:   mode_ff <= csr_wdata[1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < CHANNELS; k++) begin
            xi_ff[k] <= '0;
         end
      end else if (cmd.op == DP_INTEG) begin
         if (integ_on) begin
            xi_ff[ci] <= isat_val;
         end else if (mode_ff == WINDUP_CLEAR) begin
            xi_ff[ci] <= '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.op == DP_INTEG) begin
         ovi_ff[ci] <= integ_on && isat;
      end
      if (cmd.op == DP_LOAD) begin
         if ((opcode == OP_LOAD_X) && col_s_ok) begin
            xvec_ff[SW'(column_index)] <= value;
         end
         if ((opcode == OP_LOAD_Y) && row_ok) begin
            meas_ff[CHW'(row_index)] <= value;
         end
         if ((opcode == OP_LOAD_R) && row_ok) begin
            refv_ff[CHW'(row_index)] <= value;
         end
      end
   end

   always_ff @(posedge clock) begin
      unique case (cmd.op)
         DP_CLR_ACC: begin
            acc_ff <= '0;
         end
         DP_MUL_LX: begin
            prod_ff <= $signed(rdata_l) * xvec_ff[xe];
         end
         DP_MUL_LIXI: begin
            prod_ff <= $signed(rdata_i) * xi_ff[ie];
         end
         DP_ACC_ADD: begin
            acc_ff <= acc_ff + ACCW'(prnd);
         end
         DP_ACC_SUB: begin
            acc_ff <= acc_ff - ACCW'(prnd);
         end
         DP_DIV_INIT: begin
            rem_ff  <= '0;
            quot_ff <= nmag;
            dmag_ff <= dval[33] ? 34'(-dval) : 34'(dval);
            neg_ff  <= nval[47] ^ dval[33];
         end
         DP_DIV_STEP: begin
            rem_ff  <= rem_ge ? 34'(rem_sh - {1'b0, dmag_ff}) : rem_sh[33:0];
            quot_ff <= {quot_ff[46:0], rem_ge};
         end
         DP_MUL_FF: begin
            prod_ff <= qsat_val * refv_ff[ci];
            qsat_ff <= qpos_ov || qneg_ov;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.op == DP_DRIVE) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.op == DP_DRIVE) begin
         out_chan_ff <= 2'(cmd.chan);
         out_last_ff <= cmd.last;
         if (dzero) begin
            out_drive_ff <= '0;
            out_ovf_ff   <= 1'b1;
         end else begin
            out_drive_ff <= dsat_val;
            out_ovf_ff   <= ovi_ff[ci] || qsat_ff || dpos_ov || dneg_ov;
         end
      end
   end

   assign status.out_fire = out_valid_ff && rsp_tready;
   assign rsp_tvalid   = out_valid_ff;
   assign rsp_channel  = out_chan_ff;
   assign rsp_drive    = out_drive_ff;
   assign rsp_last     = out_last_ff;
   assign rsp_overflow = out_ovf_ff;

endmodule

>>> sv/lqi_state_feedback_with_integral_unit.sv
// LQI state-feedback controller in signed Q16.16. Load transfers are taken in the idle state and
// write the gain matrices, state, measurements and references; a compute transfer updates the
// integrators one channel at a time and then, per channel, walks STATES + CHANNELS products
// through a single product register, each with read, multiply and accumulate states, runs a
// radix-2 divider for the feedforward gain and then forms, drives and presents the result,
// waiting in the output state for as long as the output stalls.
// One item is in work at a time; new transfers are taken only once the last result has gone.
module lqi_state_feedback_with_integral_unit import lqi_pkg::*; #(
   parameter int STATES   = STATES_DEF,
   parameter int CHANNELS = CHANNELS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // opcode[2:0], row_index[4:3], column_index[7:5], value[39:8]
   input  logic [39:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // channel[1:0], drive[33:2], zero fill[39:34]
   output logic [39:0] rsp_tdata,
   output logic        rsp_tlast,
   // overflow[0]
   output logic [0:0]  rsp_tuser,
   input  logic        csr_we,
   input  logic [0:0]  csr_addr,
   input  logic [31:0] csr_wdata
);

   dp_cmd_type         cmd;
   dp_status_type      status;
   logic [1:0]         rsp_channel;
   logic signed [31:0] rsp_drive;
   logic               rsp_overflow;

   lqi_ctrl #(.STATES(STATES), .CHANNELS(CHANNELS)) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .opcode     (req_tdata[2:0]),
      .status     (status),
      .cmd        (cmd)
   );

   lqi_dp #(.STATES(STATES), .CHANNELS(CHANNELS)) u_dp (
      .clock        (clock),
      .reset        (reset),
      .csr_we       (csr_we),
      .csr_addr     (csr_addr),
      .csr_wdata    (csr_wdata),
      .opcode       (req_tdata[2:0]),
      .row_index    (req_tdata[4:3]),
      .column_index (req_tdata[7:5]),
      .value        (req_tdata[39:8]),
      .cmd          (cmd),
      .status       (status),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_channel  (rsp_channel),
      .rsp_drive    (rsp_drive),
      .rsp_last     (rsp_tlast),
      .rsp_overflow (rsp_overflow)
   );

   assign rsp_tdata = {6'b000000, rsp_drive, rsp_channel};
   assign rsp_tuser = rsp_overflow;

endmodule
